// File: hdl/paged_program_allocator_macros.svh
// Assertion macros for the paged program allocator.
// Depends on signals named clk and rst in the including module.
`ifndef PAGED_PROGRAM_ALLOCATOR_MACROS_SVH
`define PAGED_PROGRAM_ALLOCATOR_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define PPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define PPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hdl/ppa_pkg.sv
// Shared types and constants for the paged program allocator.
// No dependencies.
`timescale 1ns / 1ps
package ppa_pkg;
  localparam int PAGE_W    = 6;
  localparam int ID_W      = 16;
  localparam int SIZE_W    = 16;
  localparam int STATUS_W  = 3;
  localparam int TBL_DEPTH = 32;
  localparam int TBL_W     = 5;
  localparam int KB_W      = 13;
  localparam int NUM_PAGES_DEF = 32;
  localparam int PAGE_KB_DEF   = 100;

  localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNLOADED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd4;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_UNLOAD = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_CHK, S_POP_RD, S_POP_WR, S_LD_TERM,
    S_SCAN, S_UL_DEC, S_UL_FIRST, S_LINK_RD, S_LINK_WR, S_RESP
  } state_t;

  typedef struct packed {
    logic              rd;
    logic              pop;
    logic              push;
    logic [PAGE_W-1:0] page;
  } stack_cmd_t;
endpackage

// File: hdl/ppa_req_if.sv
// Request channel interface: valid/ready plus load/unload payload.
// Depends on ppa_pkg.
`timescale 1ns / 1ps
interface ppa_req_if;
  import ppa_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ID_W-1:0]   program_id;
  logic [SIZE_W-1:0] size_kb;
  modport source (output valid, mode, program_id, size_kb, input ready);
  modport sink   (input valid, mode, program_id, size_kb, output ready);
endinterface

// File: hdl/ppa_rsp_if.sv
// Result channel interface: valid/ready plus status and page payload.
// Depends on ppa_pkg.
`timescale 1ns / 1ps
interface ppa_rsp_if;
  import ppa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   page_number;
  logic [PAGE_W-1:0]   free_pages;
  logic                last;
  modport source (output valid, status, page_number, free_pages, last, input ready);
  modport sink   (input valid, status, page_number, free_pages, last, output ready);
endinterface

// File: hdl/ppa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ppa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: hdl/ppa_stack.sv
// Free page stack: RAM plus depth and a low-water mark.
// Entries below the mark were never written and read as their reset value.
// Depends on ppa_pkg and ppa_ram.
`timescale 1ns / 1ps
module ppa_stack #(
  parameter int NUM_PAGES = ppa_pkg::NUM_PAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ppa_pkg::stack_cmd_t       cmd,
  output logic [ppa_pkg::PAGE_W-1:0] depth,
  output logic [ppa_pkg::PAGE_W-1:0] top_page
);
  import ppa_pkg::*;
  localparam int AW = $clog2(NUM_PAGES);
  localparam logic [PAGE_W-1:0] NP = PAGE_W'(NUM_PAGES);

  logic [PAGE_W-1:0] low_mark;
  logic [PAGE_W-1:0] rd_idx;
  logic [PAGE_W-1:0] idx_q;
  logic              init_q;
  logic [PAGE_W-1:0] rdata;
  logic [PAGE_W-1:0] raw;

  assign rd_idx = depth - PAGE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth    <= NP;
      low_mark <= NP;
    end else begin
      if (cmd.pop) begin
        depth <= rd_idx;
        if (rd_idx < low_mark) begin
          low_mark <= rd_idx;
        end
      end else if (cmd.push) begin
        depth <= depth + PAGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      init_q <= (rd_idx < low_mark);
      idx_q  <= rd_idx;
    end
  end

  ppa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (depth[AW-1:0]),
    .wdata (cmd.page),
    .re    (cmd.rd),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  assign raw      = init_q ? (NP - idx_q) : rdata;
  assign top_page = (raw > NP) ? '0 : raw;
endmodule

// File: hdl/paged_program_allocator.sv
// Paged program allocator: one load or unload request is handled at a time;
// the next item is taken on return to idle.
// Unload time is set by the 32-entry owner scan through one RAM read port;
// each page move is a RAM read, then a write/emit.
// One result register decouples the output; it holds while rsp.ready is low.
`timescale 1ns / 1ps
`include "paged_program_allocator_macros.svh"
module paged_program_allocator #(
  parameter int NUM_PAGES = ppa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_KB   = ppa_pkg::PAGE_KB_DEF
) (
  input  logic  clk,
  input  logic  rst,
  ppa_req_if.sink   req,
  ppa_rsp_if.source rsp
);
  // Synchronous reset: free stack reads as pages 1..N at once (no clearing pass).
  import ppa_pkg::*;
  localparam int LAW    = $clog2(NUM_PAGES + 1);
  localparam int PROD_W = PAGE_W + KB_W;
  localparam logic [PAGE_W-1:0] NP  = PAGE_W'(NUM_PAGES);
  localparam logic [KB_W-1:0]   KB  = KB_W'(PAGE_KB);
  localparam logic [SIZE_W-1:0] KBS = SIZE_W'(PAGE_KB);
  localparam logic [TBL_W:0]    TBL_END = (TBL_W+1)'(TBL_DEPTH);

  state_t state, state_next;

  // request context
  logic [ID_W-1:0]     id_q;
  logic [SIZE_W-1:0]   rem_q;      // KB still to cover on a load
  logic [TBL_W-1:0]    slot_q;
  logic [PAGE_W-1:0]   prev_q;
  logic                first_q;
  logic [STATUS_W-1:0] resp_q;

  // owner scan
  logic [TBL_W:0]      scan_i;
  logic                cmp_v;
  logic [TBL_W-1:0]    cmp_idx;
  logic                found;
  logic [TBL_W-1:0]    best_idx;
  logic [TBL_W-1:0]    best_age;

  // unload walk
  logic [PAGE_W-1:0]   page_q;
  logic [PAGE_W-1:0]   n_q;

  // program table control bits and recency ranks
  logic                vld [TBL_DEPTH];
  logic [TBL_W-1:0]    age [TBL_DEPTH];

  logic [TBL_W-1:0]    free_slot;
  logic                slot_ok;
  logic [PROD_W-1:0]   cap_kb;
  logic                fits;

  // stack
  stack_cmd_t          scmd;
  logic [PAGE_W-1:0]   fd;
  logic [PAGE_W-1:0]   stk_top;

  // RAM ports
  logic                own_we, own_re;
  logic [ID_W-1:0]     own_rdata;
  logic                fp_we, fp_re;
  logic [PAGE_W-1:0]   fp_rdata;
  logic                lk_we, lk_re;
  logic [LAW-1:0]      lk_waddr;
  logic [PAGE_W-1:0]   lk_wdata;
  logic [PAGE_W-1:0]   lk_rdata;

  // output stage
  logic                out_free, out_load;
  logic [STATUS_W-1:0] o_status;
  logic [PAGE_W-1:0]   o_page, o_free;
  logic                o_last;
  logic                rsp_valid_q;
  logic [STATUS_W-1:0] rsp_status_q;
  logic [PAGE_W-1:0]   rsp_page_q, rsp_free_q;
  logic                rsp_last_q;

  logic                pop_last;
  logic                walk_cont;
  logic                first_ok;
  logic [PAGE_W:0]     n_inc, fd_inc;

  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp_valid_q || rsp.ready;

  // lowest empty table slot
  always_comb begin
    free_slot = '0;
    slot_ok   = 1'b0;
    for (int i = TBL_DEPTH - 1; i >= 0; i--) begin
      if (!vld[i]) begin
        slot_ok   = 1'b1;
        free_slot = TBL_W'(i);
      end
    end
  end

  // need <= free  <=>  size <= free * PAGE_KB
  assign cap_kb = PROD_W'(fd) * PROD_W'(KB);
  assign fits   = (PROD_W'(rem_q) <= cap_kb);

  assign pop_last  = (rem_q <= KBS);
  assign n_inc     = {1'b0, n_q} + (PAGE_W+1)'(1);
  assign fd_inc    = {1'b0, fd} + (PAGE_W+1)'(1);
  assign walk_cont = (lk_rdata != '0) && (lk_rdata <= NP) &&
                     (n_inc < {1'b0, NP}) && (fd_inc < {1'b0, NP});
  assign first_ok  = (fp_rdata != '0) && (fp_rdata <= NP) && (fd < NP);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.mode == MODE_UNLOAD) state_next = S_SCAN;
          else if (req.size_kb == '0) state_next = S_RESP;
          else state_next = S_LD_CHK;
        end
      end
      S_LD_CHK:   state_next = (slot_ok && fits) ? S_POP_RD : S_RESP;
      S_POP_RD:   state_next = S_POP_WR;
      S_POP_WR: begin
        if (out_free) state_next = pop_last ? S_LD_TERM : S_POP_RD;
      end
      S_LD_TERM:  state_next = S_IDLE;
      S_SCAN:     state_next = (scan_i == TBL_END) ? S_UL_DEC : S_SCAN;
      S_UL_DEC:   state_next = found ? S_UL_FIRST : S_RESP;
      S_UL_FIRST: state_next = first_ok ? S_LINK_RD : S_RESP;
      S_LINK_RD:  state_next = S_LINK_WR;
      S_LINK_WR: begin
        if (out_free) state_next = walk_cont ? S_LINK_RD : S_IDLE;
      end
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // control strobes and result fields
  always_comb begin
    scmd     = '0;
    own_we   = 1'b0;
    own_re   = 1'b0;
    fp_we    = 1'b0;
    fp_re    = 1'b0;
    lk_we    = 1'b0;
    lk_re    = 1'b0;
    lk_waddr = prev_q[LAW-1:0];
    lk_wdata = stk_top;
    out_load = 1'b0;
    o_status = resp_q;
    o_page   = '0;
    o_free   = fd;
    o_last   = 1'b1;
    case (state)
      S_LD_CHK: begin
        own_we = slot_ok && fits;
      end
      S_POP_RD: begin
        scmd.rd = 1'b1;
      end
      S_POP_WR: begin
        if (out_free) begin
          scmd.pop = 1'b1;
          fp_we    = first_q;
          lk_we    = !first_q;
          out_load = 1'b1;
          o_status = ST_LOADED;
          o_page   = stk_top;
          o_free   = fd - PAGE_W'(1);
          o_last   = pop_last;
        end
      end
      S_LD_TERM: begin
        // terminate the chain at the last page taken
        lk_we    = 1'b1;
        lk_wdata = '0;
      end
      S_SCAN: begin
        own_re = (scan_i < TBL_END);
      end
      S_UL_DEC: begin
        fp_re = found;
      end
      S_LINK_RD: begin
        lk_re = 1'b1;
      end
      S_LINK_WR: begin
        if (out_free) begin
          scmd.push = 1'b1;
          scmd.page = page_q;
          out_load  = 1'b1;
          o_status  = ST_UNLOADED;
          o_page    = page_q;
          o_free    = fd + PAGE_W'(1);
          o_last    = !walk_cont;
        end
      end
      S_RESP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // table valid bits and ranks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TBL_DEPTH; i++) vld[i] <= 1'b0;
    end else if (state == S_LD_CHK && slot_ok && fits) begin
      vld[free_slot] <= 1'b1;
    end else if (state == S_UL_DEC && found) begin
      vld[best_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LD_CHK && slot_ok && fits) begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
        if (TBL_W'(i) == free_slot) age[i] <= '0;
        else if (vld[i]) age[i] <= age[i] + TBL_W'(1);
      end
    end else if (state == S_UL_DEC && found) begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
        if (vld[i] && age[i] > best_age) age[i] <= age[i] - TBL_W'(1);
      end
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        id_q    <= req.program_id;
        rem_q   <= req.size_kb;
        resp_q  <= ST_ZERO_SIZE;
        scan_i  <= '0;
        cmp_v   <= 1'b0;
        found   <= 1'b0;
      end
      S_LD_CHK: begin
        slot_q  <= free_slot;
        first_q <= 1'b1;
        resp_q  <= ST_NO_ROOM;
      end
      S_POP_WR: begin
        if (out_free) begin
          prev_q  <= stk_top;
          first_q <= 1'b0;
          rem_q   <= rem_q - KBS;
        end
      end
      S_SCAN: begin
        if (scan_i < TBL_END) scan_i <= scan_i + (TBL_W+1)'(1);
        cmp_v   <= (scan_i < TBL_END);
        cmp_idx <= scan_i[TBL_W-1:0];
        if (cmp_v && vld[cmp_idx] && own_rdata == id_q &&
            (!found || age[cmp_idx] < best_age)) begin
          found    <= 1'b1;
          best_idx <= cmp_idx;
          best_age <= age[cmp_idx];
        end
        resp_q <= ST_NOT_FOUND;
      end
      S_UL_DEC: begin
        n_q <= '0;
      end
      S_UL_FIRST: begin
        page_q <= fp_rdata;
        resp_q <= ST_UNLOADED;
      end
      S_LINK_WR: begin
        if (out_free) begin
          page_q <= lk_rdata;
          n_q    <= n_inc[PAGE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else if (out_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_status_q <= o_status;
      rsp_page_q   <= o_page;
      rsp_free_q   <= o_free;
      rsp_last_q   <= o_last;
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.status      = rsp_status_q;
  assign rsp.page_number = rsp_page_q;
  assign rsp.free_pages  = rsp_free_q;
  assign rsp.last        = rsp_last_q;

  ppa_stack #(.NUM_PAGES(NUM_PAGES)) u_stack (
    .clk      (clk),
    .rst      (rst),
    .cmd      (scmd),
    .depth    (fd),
    .top_page (stk_top)
  );

  // owner id per table entry
  ppa_ram #(.WIDTH(ID_W), .DEPTH(TBL_DEPTH)) u_owner (
    .clk   (clk),
    .we    (own_we),
    .waddr (free_slot),
    .wdata (id_q),
    .re    (own_re),
    .raddr (scan_i[TBL_W-1:0]),
    .rdata (own_rdata)
  );

  // first page of each program's chain
  ppa_ram #(.WIDTH(PAGE_W), .DEPTH(TBL_DEPTH)) u_first (
    .clk   (clk),
    .we    (fp_we),
    .waddr (slot_q),
    .wdata (stk_top),
    .re    (fp_re),
    .raddr (best_idx),
    .rdata (fp_rdata)
  );

  // next-page links, indexed by page number
  ppa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES + 1)) u_link (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (page_q[LAW-1:0]),
    .rdata (lk_rdata)
  );

  `PPA_ASSERT_NOW(a_depth_range, 1'b1, fd <= NP, "free depth above page count")
  `PPA_ASSERT_NOW(a_no_overwrite, out_load, out_free, "result register overwritten")
  `PPA_ASSERT_NOW(a_pop_nonzero, state == S_POP_WR && out_free, stk_top != '0,
                  "popped page is zero")
  `PPA_ASSERT_NEXT(a_chk_exit, state == S_LD_CHK, state == S_POP_RD || state == S_RESP,
                   "load check went astray")
endmodule
